// File: rtl/tacmc_pkg.sv
// ----------------------------------------------------------------------------
// tacmc_pkg
// Shared types, codes and constants of the two-axis chair motion controller.
// ----------------------------------------------------------------------------
package tacmc_pkg;

   localparam int PositionBitsDefault = 12;
   localparam int PctBits             = 7;
   localparam int PctFull             = 100;
   localparam int WindowBits          = 8;
   localparam int EnableBits          = 4;
   localparam int CsrIndexBits        = 3;
   localparam int BlockBits           = 3;
   localparam int DivCountBits        = 3;

   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_UP      = 3'd1,
      MODE_DOWN    = 3'd2,
      MODE_FORWARD = 3'd3,
      MODE_BACK    = 3'd4,
      MODE_STOP    = 3'd5,
      MODE_GO      = 3'd6
   } mode_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_UP_LIMIT      = 3'd0,
      CSR_DOWN_LIMIT    = 3'd1,
      CSR_FORWARD_LIMIT = 3'd2,
      CSR_BACK_LIMIT    = 3'd3,
      CSR_LIMIT_ENABLES = 3'd4,
      CSR_ARRIVE_WINDOW = 3'd5
   } csr_index_type;

   localparam logic [BlockBits-1:0] BLOCK_NONE    = 3'd0;
   localparam logic [BlockBits-1:0] BLOCK_UP      = 3'd1;
   localparam logic [BlockBits-1:0] BLOCK_DOWN    = 3'd2;
   localparam logic [BlockBits-1:0] BLOCK_FORWARD = 3'd3;
   localparam logic [BlockBits-1:0] BLOCK_BACK    = 3'd4;

   // limit enable bit positions
   localparam int EnUp      = 0;
   localparam int EnDown    = 1;
   localparam int EnForward = 2;
   localparam int EnBack    = 3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic prep;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tick_auto;
      logic zero_start;
      logic div_last;
   } dp_status_type;

endpackage

// File: rtl/tacmc_ctrl.sv
// ----------------------------------------------------------------------------
// tacmc_ctrl
// Sequencer: takes one transaction, runs the update, the progress divide
// when a tick of an automatic move needs it, and holds the result.
// ----------------------------------------------------------------------------
module tacmc_ctrl
   import tacmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_PREP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.tick_auto ? ST_PREP : ST_RESP;
         end
         ST_PREP: begin
            state_in = status.zero_start ? ST_RESP : ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = (state_ff == ST_RESP);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign cmd.prep    = (state_ff == ST_PREP);
   assign cmd.step    = (state_ff == ST_DIV);

endmodule

// File: rtl/tacmc_datapath.sv
// ----------------------------------------------------------------------------
// tacmc_datapath
// Control registers, relay and move state, position error logic and a
// one-bit-per-cycle restoring divider for the progress percentage.
// ----------------------------------------------------------------------------
module tacmc_datapath
   import tacmc_pkg::*;
#(
   parameter int POSITION_BITS = PositionBitsDefault
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CsrIndexBits-1:0]  csr_index,
   input  logic [POSITION_BITS-1:0] csr_wdata,
   input  logic [2:0]               req_mode,
   input  logic [POSITION_BITS-1:0] req_vertical_sample,
   input  logic [POSITION_BITS-1:0] req_horizontal_sample,
   input  logic [POSITION_BITS-1:0] req_target_vertical,
   input  logic [POSITION_BITS-1:0] req_target_horizontal,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   output logic                     rsp_drive_up,
   output logic                     rsp_drive_down,
   output logic                     rsp_drive_forward,
   output logic                     rsp_drive_back,
   output logic                     rsp_pump_on,
   output logic                     rsp_auto_active,
   output logic [PctBits-1:0]       rsp_progress_pct,
   output logic                     rsp_arrived,
   output logic [BlockBits-1:0]     rsp_block_code
);

   localparam int DistBits = POSITION_BITS + 1;
   localparam int NumBits  = DistBits + PctBits;

   // control registers
   logic [POSITION_BITS-1:0] up_limit_ff, down_limit_ff, forward_limit_ff, back_limit_ff;
   logic [EnableBits-1:0]    limit_enables_ff;
   logic [WindowBits-1:0]    arrive_window_ff;

   // captured transaction
   logic [2:0]               mode_ff;
   logic [POSITION_BITS-1:0] vs_ff, hs_ff, tv_ff, th_ff;

   // move state
   logic up_ff, down_ff, forward_ff, back_ff, pump_ff, auto_ff, pending_ff;
   logic up_in, down_in, forward_in, back_in, pump_in, auto_in, pending_in;
   logic [POSITION_BITS-1:0] goal_v_ff, goal_h_ff, goal_v_in, goal_h_in;
   logic [DistBits-1:0]      start_ff, start_in;
   logic [DistBits-1:0]      remain_ff;

   // result and divider
   logic [PctBits-1:0]       pct_ff;
   logic                     arrived_ff, arrived_in;
   logic [BlockBits-1:0]     block_ff, block_in;
   logic [NumBits-1:0]       num_ff;
   logic [DivCountBits-1:0]  cnt_ff;

   logic [POSITION_BITS-1:0] err_v, err_h, band;
   logic [DistBits-1:0]      remain, covered;
   logic                     done_v, done_h;
   logic [NumBits-1:0]       shifted_den, numer;
   logic                     fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_limit_ff      <= '1;
         down_limit_ff    <= '0;
         forward_limit_ff <= '1;
         back_limit_ff    <= '0;
         limit_enables_ff <= '0;
         arrive_window_ff <= WindowBits'(20);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_UP_LIMIT:      up_limit_ff      <= csr_wdata;
            CSR_DOWN_LIMIT:    down_limit_ff    <= csr_wdata;
            CSR_FORWARD_LIMIT: forward_limit_ff <= csr_wdata;
            CSR_BACK_LIMIT:    back_limit_ff    <= csr_wdata;
            CSR_LIMIT_ENABLES: limit_enables_ff <= csr_wdata[EnableBits-1:0];
            CSR_ARRIVE_WINDOW: arrive_window_ff <= csr_wdata[WindowBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         vs_ff   <= req_vertical_sample;
         hs_ff   <= req_horizontal_sample;
         tv_ff   <= req_target_vertical;
         th_ff   <= req_target_horizontal;
      end
   end

   assign err_v  = (vs_ff >= goal_v_ff) ? vs_ff - goal_v_ff : goal_v_ff - vs_ff;
   assign err_h  = (hs_ff >= goal_h_ff) ? hs_ff - goal_h_ff : goal_h_ff - hs_ff;
   assign remain = DistBits'(err_v) + DistBits'(err_h);
   assign band   = POSITION_BITS'(arrive_window_ff);
   assign done_v = (err_v <= band);
   assign done_h = (err_h <= band);

   always_comb begin
      up_in      = up_ff;
      down_in    = down_ff;
      forward_in = forward_ff;
      back_in    = back_ff;
      pump_in    = pump_ff;
      auto_in    = auto_ff;
      pending_in = pending_ff;
      goal_v_in  = goal_v_ff;
      goal_h_in  = goal_h_ff;
      start_in   = start_ff;
      arrived_in = 1'b0;
      block_in   = BLOCK_NONE;
      unique case (mode_ff)
         MODE_TICK: begin
            if (auto_ff) begin
               if (pending_ff) begin
                  start_in   = remain;
                  pending_in = 1'b0;
               end
               if (done_v) begin
                  up_in   = 1'b0;
                  down_in = 1'b0;
               end else begin
                  up_in   = (vs_ff < goal_v_ff);
                  down_in = !(vs_ff < goal_v_ff);
               end
               if (done_h) begin
                  forward_in = 1'b0;
                  back_in    = 1'b0;
               end else begin
                  forward_in = (hs_ff < goal_h_ff);
                  back_in    = !(hs_ff < goal_h_ff);
               end
               pump_in = up_in || forward_in;
               if (done_v && done_h) begin
                  up_in      = 1'b0;
                  down_in    = 1'b0;
                  forward_in = 1'b0;
                  back_in    = 1'b0;
                  pump_in    = 1'b0;
                  auto_in    = 1'b0;
                  arrived_in = 1'b1;
               end
            end
         end
         MODE_UP: begin
            if (limit_enables_ff[EnUp] && vs_ff >= up_limit_ff) begin
               block_in = BLOCK_UP;
            end else begin
               down_in = 1'b0;
               up_in   = 1'b1;
               pump_in = 1'b1;
            end
         end
         MODE_DOWN: begin
            if (limit_enables_ff[EnDown] && vs_ff <= down_limit_ff) begin
               block_in = BLOCK_DOWN;
            end else begin
               if (up_ff) begin
                  up_in   = 1'b0;
                  pump_in = forward_ff;
               end
               down_in = 1'b1;
            end
         end
         MODE_FORWARD: begin
            if (limit_enables_ff[EnForward] && hs_ff >= forward_limit_ff) begin
               block_in = BLOCK_FORWARD;
            end else begin
               back_in    = 1'b0;
               forward_in = 1'b1;
               pump_in    = 1'b1;
            end
         end
         MODE_BACK: begin
            if (limit_enables_ff[EnBack] && hs_ff <= back_limit_ff) begin
               block_in = BLOCK_BACK;
            end else begin
               if (forward_ff) begin
                  forward_in = 1'b0;
                  pump_in    = up_ff;
               end
               back_in = 1'b1;
            end
         end
         MODE_STOP: begin
            up_in      = 1'b0;
            down_in    = 1'b0;
            forward_in = 1'b0;
            back_in    = 1'b0;
            pump_in    = 1'b0;
            auto_in    = 1'b0;
         end
         MODE_GO: begin
            up_in      = 1'b0;
            down_in    = 1'b0;
            forward_in = 1'b0;
            back_in    = 1'b0;
            pump_in    = 1'b0;
            auto_in    = 1'b1;
            pending_in = 1'b1;
            goal_v_in  = tv_ff;
            goal_h_in  = th_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff      <= 1'b0;
         down_ff    <= 1'b0;
         forward_ff <= 1'b0;
         back_ff    <= 1'b0;
         pump_ff    <= 1'b0;
         auto_ff    <= 1'b0;
         pending_ff <= 1'b0;
         goal_v_ff  <= '0;
         goal_h_ff  <= '0;
         start_ff   <= '0;
      end else if (cmd.exec) begin
         up_ff      <= up_in;
         down_ff    <= down_in;
         forward_ff <= forward_in;
         back_ff    <= back_in;
         pump_ff    <= pump_in;
         auto_ff    <= auto_in;
         pending_ff <= pending_in;
         goal_v_ff  <= goal_v_in;
         goal_h_ff  <= goal_h_in;
         start_ff   <= start_in;
      end
   end

   // progress = (start - min(remain, start)) * 100 / start
   assign covered     = (remain_ff < start_ff) ? start_ff - remain_ff : '0;
   assign numer       = NumBits'(covered) * NumBits'(PctFull);
   assign shifted_den = NumBits'(start_ff) << cnt_ff;
   assign fits        = (num_ff >= shifted_den);

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         remain_ff  <= remain;
         pct_ff     <= '0;
         arrived_ff <= arrived_in;
         block_ff   <= block_in;
      end else if (cmd.prep) begin
         num_ff <= numer;
         cnt_ff <= DivCountBits'(PctBits - 1);
         pct_ff <= (start_ff == '0) ? PctBits'(PctFull) : '0;
      end else if (cmd.step) begin
         if (fits) num_ff <= num_ff - shifted_den;
         pct_ff <= {pct_ff[PctBits-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign status.tick_auto  = (mode_ff == MODE_TICK) && auto_ff;
   assign status.zero_start = (start_ff == '0);
   assign status.div_last   = (cnt_ff == '0);

   assign rsp_drive_up      = up_ff;
   assign rsp_drive_down    = down_ff;
   assign rsp_drive_forward = forward_ff;
   assign rsp_drive_back    = back_ff;
   assign rsp_pump_on       = pump_ff;
   assign rsp_auto_active   = auto_ff;
   assign rsp_progress_pct  = pct_ff;
   assign rsp_arrived       = arrived_ff;
   assign rsp_block_code    = block_ff;

endmodule

// File: rtl/two_axis_chair_motion_control.sv
// ----------------------------------------------------------------------------
// two_axis_chair_motion_control
// Relay, pump and automatic positioning control for a two-axis chair.
// ----------------------------------------------------------------------------
// One transaction at a time: manual, stop, go, an idle tick and an unused mode
// pass through the update state and then give their result. A tick of an
// automatic move adds a state that forms the progress numerator and then runs
// the serial restoring divider that yields the percentage, one quotient bit per
// cycle; when the starting distance is zero the divider is skipped. The result
// is held until taken and the next request is accepted in the cycle after that.
// Relay outputs show the state left by the transaction; no clearing pass is
// needed after reset.
module two_axis_chair_motion_control
   import tacmc_pkg::*;
#(
   parameter int POSITION_BITS = PositionBitsDefault
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CsrIndexBits-1:0]  csr_index,
   input  logic [POSITION_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_mode,
   input  logic [POSITION_BITS-1:0] req_vertical_sample,
   input  logic [POSITION_BITS-1:0] req_horizontal_sample,
   input  logic [POSITION_BITS-1:0] req_target_vertical,
   input  logic [POSITION_BITS-1:0] req_target_horizontal,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_drive_up,
   output logic                     rsp_drive_down,
   output logic                     rsp_drive_forward,
   output logic                     rsp_drive_back,
   output logic                     rsp_pump_on,
   output logic                     rsp_auto_active,
   output logic [PctBits-1:0]       rsp_progress_pct,
   output logic                     rsp_arrived,
   output logic [BlockBits-1:0]     rsp_block_code
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   tacmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tacmc_datapath #(
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wen               (csr_wen),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_mode              (req_mode),
      .req_vertical_sample   (req_vertical_sample),
      .req_horizontal_sample (req_horizontal_sample),
      .req_target_vertical   (req_target_vertical),
      .req_target_horizontal (req_target_horizontal),
      .cmd                   (cmd),
      .status                (status),
      .rsp_drive_up          (rsp_drive_up),
      .rsp_drive_down        (rsp_drive_down),
      .rsp_drive_forward     (rsp_drive_forward),
      .rsp_drive_back        (rsp_drive_back),
      .rsp_pump_on           (rsp_pump_on),
      .rsp_auto_active       (rsp_auto_active),
      .rsp_progress_pct      (rsp_progress_pct),
      .rsp_arrived           (rsp_arrived),
      .rsp_block_code        (rsp_block_code)
   );

endmodule

// File: rtl/tacmc_checker.sv
// ----------------------------------------------------------------------------
// tacmc_checker
// Port-level checks on the result channel of the chair motion controller.
// ----------------------------------------------------------------------------
module tacmc_checker
   import tacmc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_drive_up,
   input logic               rsp_drive_down,
   input logic               rsp_drive_forward,
   input logic               rsp_drive_back,
   input logic               rsp_pump_on,
   input logic               rsp_auto_active,
   input logic [PctBits-1:0] rsp_progress_pct,
   input logic               rsp_arrived
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_progress_pct))
      else $error("stalled transaction changed");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_progress_pct <= PctBits'(PctFull))
      else $error("progress above full scale");

   a_relay_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_drive_up && rsp_drive_down) &&
                    !(rsp_drive_forward && rsp_drive_back))
      else $error("opposing relays both active");

   a_pump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pump_on == (rsp_drive_up || rsp_drive_forward))
      else $error("pump does not follow up or forward drive");

   a_arrived: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> !rsp_auto_active && !rsp_drive_up &&
         !rsp_drive_down && !rsp_drive_forward && !rsp_drive_back)
      else $error("arrival with drives still active");

endmodule

bind two_axis_chair_motion_control tacmc_checker u_tacmc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_drive_up      (rsp_drive_up),
   .rsp_drive_down    (rsp_drive_down),
   .rsp_drive_forward (rsp_drive_forward),
   .rsp_drive_back    (rsp_drive_back),
   .rsp_pump_on       (rsp_pump_on),
   .rsp_auto_active   (rsp_auto_active),
   .rsp_progress_pct  (rsp_progress_pct),
   .rsp_arrived       (rsp_arrived)
);

// File: tb/tacmc_checker.sv
// ----------------------------------------------------------------------------
// tacmc_scoreboard
// Watches the request, result and register ports of the chair controller,
// keeps its own model of relays, pump, automatic move and limits, and checks
// every result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tacmc_scoreboard
   import tacmc_pkg::*;
#(
   parameter int POSITION_BITS = PositionBitsDefault
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CsrIndexBits-1:0]  csr_index,
   input  logic [POSITION_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [2:0]               req_mode,
   input  logic [POSITION_BITS-1:0] req_vertical_sample,
   input  logic [POSITION_BITS-1:0] req_horizontal_sample,
   input  logic [POSITION_BITS-1:0] req_target_vertical,
   input  logic [POSITION_BITS-1:0] req_target_horizontal,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     rsp_drive_up,
   input  logic                     rsp_drive_down,
   input  logic                     rsp_drive_forward,
   input  logic                     rsp_drive_back,
   input  logic                     rsp_pump_on,
   input  logic                     rsp_auto_active,
   input  logic [PctBits-1:0]       rsp_progress_pct,
   input  logic                     rsp_arrived,
   input  logic [BlockBits-1:0]     rsp_block_code,
   output int                       mismatches,
   output int                       owed,
   output int                       auto_ticks,
   output int                       arrivals,
   output int                       blocks
);

   typedef struct packed {
      logic                 up;
      logic                 down;
      logic                 fwd;
      logic                 back;
      logic                 pump;
      logic                 auto_on;
      logic [PctBits-1:0]   pct;
      logic                 arrived;
      logic [BlockBits-1:0] block;
   } chair_result_type;

   chair_result_type expected_q[$];

   // register copies
   logic [POSITION_BITS-1:0] up_lim, down_lim, fwd_lim, back_lim;
   logic [EnableBits-1:0]    limit_en;
   logic [WindowBits-1:0]    arrive_win;

   // relay and move state
   logic                     up_on, down_on, fwd_on, back_on, pump_run;
   logic                     moving, need_start;
   logic [POSITION_BITS-1:0] goal_v, goal_h;
   logic [POSITION_BITS:0]   start_dist;
   int                       results_seen;

   function automatic logic [POSITION_BITS-1:0] abs_gap(input logic [POSITION_BITS-1:0] a,
                                                        input logic [POSITION_BITS-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   task automatic stop_all();
      up_on    = 1'b0;
      down_on  = 1'b0;
      fwd_on   = 1'b0;
      back_on  = 1'b0;
      pump_run = 1'b0;
      moving   = 1'b0;
   endtask

   task automatic note_failure(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task automatic step_chair(input  logic [2:0]               m,
                             input  logic [POSITION_BITS-1:0] vs,
                             input  logic [POSITION_BITS-1:0] hs,
                             input  logic [POSITION_BITS-1:0] tv,
                             input  logic [POSITION_BITS-1:0] th,
                             output chair_result_type         r);
      logic [POSITION_BITS-1:0] ev, eh;
      logic [POSITION_BITS:0]   rem, lesser;
      logic                     done_v, done_h, hit;
      logic [BlockBits-1:0]     blk;
      int                       pct;
      pct = 0;
      hit = 1'b0;
      blk = BLOCK_NONE;
      case (m)
         MODE_TICK: begin
            if (moving) begin
               ev     = abs_gap(vs, goal_v);
               eh     = abs_gap(hs, goal_h);
               rem    = {1'b0, ev} + {1'b0, eh};
               done_v = ev <= arrive_win;
               done_h = eh <= arrive_win;
               // first tick after go fixes the starting distance
               if (need_start) begin
                  start_dist = rem;
                  need_start = 1'b0;
               end
               if (start_dist != 0) begin
                  lesser = (rem < start_dist) ? rem : start_dist;
                  pct = (int'(start_dist - lesser) * PctFull) / int'(start_dist);
               end else begin
                  pct = PctFull;
               end
               if (done_v) begin
                  up_on   = 1'b0;
                  down_on = 1'b0;
               end else if (vs < goal_v) begin
                  up_on   = 1'b1;
                  down_on = 1'b0;
               end else begin
                  up_on   = 1'b0;
                  down_on = 1'b1;
               end
               if (done_h) begin
                  fwd_on  = 1'b0;
                  back_on = 1'b0;
               end else if (hs < goal_h) begin
                  fwd_on  = 1'b1;
                  back_on = 1'b0;
               end else begin
                  fwd_on  = 1'b0;
                  back_on = 1'b1;
               end
               pump_run = up_on | fwd_on;
               if (done_v && done_h) begin
                  stop_all();
                  hit = 1'b1;
                  arrivals++;
               end
               auto_ticks++;
            end
         end
         MODE_UP: begin
            if (limit_en[EnUp] && vs >= up_lim) begin
               blk = BLOCK_UP;
            end else begin
               down_on  = 1'b0;
               up_on    = 1'b1;
               pump_run = 1'b1;
            end
         end
         MODE_DOWN: begin
            if (limit_en[EnDown] && vs <= down_lim) begin
               blk = BLOCK_DOWN;
            end else begin
               if (up_on) begin
                  up_on    = 1'b0;
                  pump_run = fwd_on;
               end
               down_on = 1'b1;
            end
         end
         MODE_FORWARD: begin
            if (limit_en[EnForward] && hs >= fwd_lim) begin
               blk = BLOCK_FORWARD;
            end else begin
               back_on  = 1'b0;
               fwd_on   = 1'b1;
               pump_run = 1'b1;
            end
         end
         MODE_BACK: begin
            if (limit_en[EnBack] && hs <= back_lim) begin
               blk = BLOCK_BACK;
            end else begin
               if (fwd_on) begin
                  fwd_on   = 1'b0;
                  pump_run = up_on;
               end
               back_on = 1'b1;
            end
         end
         MODE_STOP: begin
            stop_all();
         end
         MODE_GO: begin
            stop_all();
            goal_v     = tv;
            goal_h     = th;
            moving     = 1'b1;
            need_start = 1'b1;
         end
         default: begin
         end
      endcase
      if (blk != BLOCK_NONE) blocks++;
      r.up      = up_on;
      r.down    = down_on;
      r.fwd     = fwd_on;
      r.back    = back_on;
      r.pump    = pump_run;
      r.auto_on = moving;
      r.pct     = pct[PctBits-1:0];
      r.arrived = hit;
      r.block   = blk;
   endtask

   always @(posedge clock) begin
      chair_result_type want, got;
      if (reset) begin
         up_lim       = '1;
         down_lim     = '0;
         fwd_lim      = '1;
         back_lim     = '0;
         limit_en     = '0;
         arrive_win   = 8'd20;
         stop_all();
         need_start   = 1'b0;
         goal_v       = '0;
         goal_h       = '0;
         start_dist   = '0;
         results_seen = 0;
         mismatches   = 0;
         auto_ticks   = 0;
         arrivals     = 0;
         blocks       = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               note_failure($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
               want        = expected_q.pop_front();
               got.up      = rsp_drive_up;
               got.down    = rsp_drive_down;
               got.fwd     = rsp_drive_forward;
               got.back    = rsp_drive_back;
               got.pump    = rsp_pump_on;
               got.auto_on = rsp_auto_active;
               got.pct     = rsp_progress_pct;
               got.arrived = rsp_arrived;
               got.block   = rsp_block_code;
               if (got.up !== want.up)
                  note_failure($sformatf("result %0d drive_up %b, expected %b",
                                         results_seen, got.up, want.up));
               if (got.down !== want.down)
                  note_failure($sformatf("result %0d drive_down %b, expected %b",
                                         results_seen, got.down, want.down));
               if (got.fwd !== want.fwd)
                  note_failure($sformatf("result %0d drive_forward %b, expected %b",
                                         results_seen, got.fwd, want.fwd));
               if (got.back !== want.back)
                  note_failure($sformatf("result %0d drive_back %b, expected %b",
                                         results_seen, got.back, want.back));
               if (got.pump !== want.pump)
                  note_failure($sformatf("result %0d pump_on %b, expected %b",
                                         results_seen, got.pump, want.pump));
               if (got.auto_on !== want.auto_on)
                  note_failure($sformatf("result %0d auto_active %b, expected %b",
                                         results_seen, got.auto_on, want.auto_on));
               if (got.pct !== want.pct)
                  note_failure($sformatf("result %0d progress_pct %0d, expected %0d",
                                         results_seen, got.pct, want.pct));
               if (got.arrived !== want.arrived)
                  note_failure($sformatf("result %0d arrived %b, expected %b",
                                         results_seen, got.arrived, want.arrived));
               if (got.block !== want.block)
                  note_failure($sformatf("result %0d block_code %0d, expected %0d",
                                         results_seen, got.block, want.block));
            end
         end
         if (csr_wen) begin
            case (csr_index)
               CSR_UP_LIMIT:      up_lim     = csr_wdata;
               CSR_DOWN_LIMIT:    down_lim   = csr_wdata;
               CSR_FORWARD_LIMIT: fwd_lim    = csr_wdata;
               CSR_BACK_LIMIT:    back_lim   = csr_wdata;
               CSR_LIMIT_ENABLES: limit_en   = csr_wdata[EnableBits-1:0];
               CSR_ARRIVE_WINDOW: arrive_win = csr_wdata[WindowBits-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            step_chair(req_mode, req_vertical_sample, req_horizontal_sample,
                       req_target_vertical, req_target_horizontal, want);
            expected_q.push_back(want);
         end
      end
      owed = expected_q.size();
   end

endmodule

// File: tb/tb_two_axis_chair_motion_control.sv
// ----------------------------------------------------------------------------
// tb_two_axis_chair_motion_control
// Drives manual, stop, go and tick transactions into the chair controller with
// random request gaps and result back-pressure, across several limit and dead
// band settings, and reports the verdict from the checker's failure and owed counts.
// ----------------------------------------------------------------------------
module tb_two_axis_chair_motion_control;
   import tacmc_pkg::*;

   localparam int         PosBits       = PositionBitsDefault;
   localparam int         PosTop        = (1 << PosBits) - 1;
   localparam int         IdleLimit     = 1000;
   localparam int         RandomPhases  = 10;
   localparam int         ItemsPerPhase = 200;
   localparam logic [2:0] MODE_UNUSED   = 3'd7;

   typedef struct {
      logic [PosBits-1:0] up_lim;
      logic [PosBits-1:0] down_lim;
      logic [PosBits-1:0] fwd_lim;
      logic [PosBits-1:0] back_lim;
      logic [PosBits-1:0] enables;
      logic [PosBits-1:0] window;
   } chair_cfg_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wen;
   logic [CsrIndexBits-1:0] csr_index;
   logic [PosBits-1:0]      csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   logic [2:0]              req_mode;
   logic [PosBits-1:0]      req_vertical_sample;
   logic [PosBits-1:0]      req_horizontal_sample;
   logic [PosBits-1:0]      req_target_vertical;
   logic [PosBits-1:0]      req_target_horizontal;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_drive_up;
   logic                    rsp_drive_down;
   logic                    rsp_drive_forward;
   logic                    rsp_drive_back;
   logic                    rsp_pump_on;
   logic                    rsp_auto_active;
   logic [PctBits-1:0]      rsp_progress_pct;
   logic                    rsp_arrived;
   logic [BlockBits-1:0]    rsp_block_code;

   int mismatches, owed, auto_ticks, arrivals, blocks;

   int                 items_sent;
   int                 settings_loaded;
   bit                 quiet;
   chair_cfg_type      cfg_now;
   logic [PosBits-1:0] cur_v, cur_h;

   two_axis_chair_motion_control #(.POSITION_BITS(PosBits)) i_dut (.*);

   tacmc_scoreboard #(.POSITION_BITS(PosBits)) i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PosBits-1:0] rand_pos();
      return PosBits'($urandom_range(0, PosTop));
   endfunction

   function automatic logic [2:0] rand_manual();
      return 3'($urandom_range(MODE_UP, MODE_BACK));
   endfunction

   // sample just below, at or above a limit, or anywhere
   function automatic logic [PosBits-1:0] near_limit(input logic [PosBits-1:0] lim);
      case ($urandom_range(0, 3))
         0:       return lim - 1'b1;
         1:       return lim;
         2:       return lim + 1'b1;
         default: return rand_pos();
      endcase
   endfunction

   function automatic logic [PosBits-1:0] approach(input logic [PosBits-1:0] src,
                                                   input logic [PosBits-1:0] dst);
      int stride, nxt;
      stride = $urandom_range(0, 600);
      if ($urandom_range(0, 9) == 0) return rand_pos();
      if (src < dst) nxt = (int'(src) + stride > int'(dst)) ? int'(dst) : int'(src) + stride;
      else           nxt = (int'(src) - stride < int'(dst)) ? int'(dst) : int'(src) - stride;
      return nxt[PosBits-1:0];
   endfunction

   // result side back-pressure, with occasional stretches of none
   initial begin : rsp_side
      int stall, run;
      rsp_ready = 1'b0;
      stall = 0;
      run = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (run > 0) run--;
            else if ($urandom_range(0, 49) == 0) run = $urandom_range(50, 300);
            else stall = gap_len();
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("Test completed with failures");
      $finish;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [2:0]         m,
                            input logic [PosBits-1:0] vs,
                            input logic [PosBits-1:0] hs,
                            input logic [PosBits-1:0] tv,
                            input logic [PosBits-1:0] th);
      int gap;
      req_valid             <= 1'b1;
      req_mode              <= m;
      req_vertical_sample   <= vs;
      req_horizontal_sample <= hs;
      req_target_vertical   <= tv;
      req_target_horizontal <= th;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      gap = quiet ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [PosBits-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // only while the block is idle
   task automatic load_config(input chair_cfg_type cfg);
      csr_put(CSR_UP_LIMIT, cfg.up_lim);
      csr_put(CSR_DOWN_LIMIT, cfg.down_lim);
      csr_put(CSR_FORWARD_LIMIT, cfg.fwd_lim);
      csr_put(CSR_BACK_LIMIT, cfg.back_lim);
      csr_put(CSR_LIMIT_ENABLES, cfg.enables);
      csr_put(CSR_ARRIVE_WINDOW, cfg.window);
      csr_wen <= 1'b0;
      @(negedge clock);
      cfg_now = cfg;
      settings_loaded++;
   endtask

   task automatic run_move();
      logic [PosBits-1:0] tv, th;
      int                 n;
      if ($urandom_range(0, 3) == 0) begin
         // target close to where the chair already is
         tv = PosBits'(cur_v + $urandom_range(0, 60) - 30);
         th = PosBits'(cur_h + $urandom_range(0, 60) - 30);
      end else begin
         tv = rand_pos();
         th = rand_pos();
      end
      send_item(MODE_GO, cur_v, cur_h, tv, th);
      n = $urandom_range(1, 16);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(rand_manual(), cur_v, cur_h, rand_pos(), rand_pos());
         end else begin
            cur_v = approach(cur_v, tv);
            cur_h = approach(cur_h, th);
            send_item(MODE_TICK, cur_v, cur_h, rand_pos(), rand_pos());
         end
      end
      if ($urandom_range(0, 4) == 0) send_item(MODE_STOP, cur_v, cur_h, rand_pos(), rand_pos());
   endtask

   task automatic run_manual();
      logic [2:0]         m;
      logic [PosBits-1:0] vs, hs;
      int                 n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         m  = rand_manual();
         vs = near_limit($urandom_range(0, 1) ? cfg_now.up_lim : cfg_now.down_lim);
         hs = near_limit($urandom_range(0, 1) ? cfg_now.fwd_lim : cfg_now.back_lim);
         send_item(m, vs, hs, rand_pos(), rand_pos());
      end
   endtask

   initial begin : stimulus
      chair_cfg_type cfg;
      int            phase_start;
      reset                 = 1'b1;
      csr_wen               = 1'b0;
      csr_index             = CSR_UP_LIMIT;
      csr_wdata             = '0;
      req_valid             = 1'b0;
      req_mode              = MODE_TICK;
      req_vertical_sample   = '0;
      req_horizontal_sample = '0;
      req_target_vertical   = '0;
      req_target_horizontal = '0;
      items_sent            = 0;
      settings_loaded       = 0;
      quiet                 = 1'b0;
      cur_v                 = 12'd2048;
      cur_h                 = 12'd2048;
      cfg_now               = '{'1, '0, '1, '0, '0, 12'd20};
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // reset settings: no limits enabled, dead band 20
      send_item(MODE_TICK, '0, '0, '1, '1);
      send_item(MODE_UNUSED, '1, '1, '1, '1);
      send_item(MODE_UP, 12'd100, 12'd100, '0, '0);
      send_item(MODE_FORWARD, 12'd100, 12'd100, '0, '0);
      send_item(MODE_DOWN, 12'd100, 12'd100, '0, '0);
      send_item(MODE_BACK, 12'd100, 12'd100, '0, '0);
      send_item(MODE_UP, 12'd100, 12'd100, '0, '0);
      send_item(MODE_STOP, 12'd100, 12'd100, '0, '0);
      send_item(MODE_GO, '0, '0, '1, '1);
      send_item(MODE_TICK, '0, '0, '0, '0);
      send_item(MODE_TICK, 12'd2000, 12'd3000, '0, '0);
      send_item(MODE_UP, 12'd2000, 12'd3000, '0, '0);
      send_item(MODE_TICK, '1, '1, '0, '0);
      // zero starting distance
      send_item(MODE_GO, 12'd500, 12'd500, 12'd500, 12'd500);
      send_item(MODE_TICK, 12'd500, 12'd500, '0, '0);
      // remaining distance grows past the start
      send_item(MODE_GO, 12'd1000, 12'd1000, 12'd1000, 12'd1050);
      send_item(MODE_TICK, 12'd1000, 12'd1000, '0, '0);
      send_item(MODE_TICK, 12'd1000, 12'd1200, '0, '0);
      send_item(MODE_STOP, 12'd1000, 12'd1200, '0, '0);
      wait_idle();

      // all limits on, zero dead band
      load_config('{12'd2000, 12'd1000, 12'd3000, 12'd500, 12'hF, 12'd0});
      send_item(MODE_UP, 12'd2000, '1, '0, '0);
      send_item(MODE_UP, 12'd1999, '1, '0, '0);
      send_item(MODE_DOWN, 12'd1000, '0, '0, '0);
      send_item(MODE_FORWARD, '0, 12'd3000, '0, '0);
      send_item(MODE_BACK, '1, 12'd500, '0, '0);
      send_item(MODE_BACK, '0, 12'd501, '0, '0);
      send_item(MODE_GO, 12'd10, 12'd10, 12'd10, 12'd10);
      send_item(MODE_TICK, 12'd10, 12'd10, '0, '0);
      wait_idle();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: cfg = '{'0, '0, '0, '0, 12'hF, '0};
            1: cfg = '{'1, '1, '1, '1, '1, '1};
            2: cfg = '{'1, '0, '1, '0, '0, 12'd20};
            default: begin
               cfg.up_lim   = rand_pos();
               cfg.down_lim = rand_pos();
               cfg.fwd_lim  = rand_pos();
               cfg.back_lim = rand_pos();
               cfg.enables  = $urandom_range(0, 1) ? rand_pos() : ('1);
               cfg.window   = $urandom_range(0, 1) ? rand_pos() :
                                                     PosBits'($urandom_range(0, 40));
            end
         endcase
         load_config(cfg);
         quiet = ($urandom_range(0, 3) == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < ItemsPerPhase) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: run_move();
               6, 7:             run_manual();
               8:                send_item(3'($urandom_range(MODE_TICK, MODE_UNUSED)),
                                           rand_pos(), rand_pos(), rand_pos(), rand_pos());
               default:          send_item(MODE_STOP, rand_pos(), rand_pos(),
                                           rand_pos(), rand_pos());
            endcase
            // hold the sender until every result is back
            if ($urandom_range(0, 39) == 0) wait_idle();
         end
         wait_idle();
      end

      repeat (20) @(negedge clock);
      $display("covered %0d transactions over %0d register settings", items_sent,
               settings_loaded);
      $display("automatic ticks %0d, arrivals %0d, limit blocks %0d", auto_ticks, arrivals,
               blocks);
      if (owed != 0) $display("%0d results never arrived", owed);
      if (mismatches == 0 && owed == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
